/* hdl/display_command_framer_crc16_top_assert.svh */
// Assertion macros for the display command framer checker.
// Used by dcf_checker.sv; expects signals named clk and rst_n in scope.
`ifndef DISPLAY_COMMAND_FRAMER_CRC16_TOP_ASSERT_SVH
`define DISPLAY_COMMAND_FRAMER_CRC16_TOP_ASSERT_SVH

// Checked only outside reset.
`define DCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define DCF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/dcf_pkg.sv */
// Shared types, constants and functions of the display command framer.
// No dependencies; the design modules of the block import it.
package dcf_pkg;

  localparam int DCF_QUEUE_DEPTH = 4;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic ACT_BEGIN = 1'b0;
  localparam logic ACT_DATA  = 1'b1;

  localparam logic [2:0] KIND_VAR_WR   = 3'd0;
  localparam logic [2:0] KIND_VAR_RD   = 3'd1;
  localparam logic [2:0] KIND_CURVE_WR = 3'd2;
  localparam logic [2:0] KIND_REG_WR   = 3'd3;
  localparam logic [2:0] KIND_REG_RD   = 3'd4;

  localparam logic [1:0] REG_CRC_ENABLE    = 2'd0;
  localparam logic [1:0] REG_WRITE_CODE    = 2'd1;
  localparam logic [1:0] REG_VAR_READ_CODE = 2'd2;
  localparam logic [1:0] REG_REG_READ_CODE = 2'd3;

  localparam logic [7:0] SYNC_HI     = 8'h5A;
  localparam logic [7:0] SYNC_LO     = 8'hA5;
  localparam logic [7:0] LEN_VAR_RD  = 8'h04;
  localparam logic [7:0] LEN_REG_RD  = 8'h03;
  localparam logic [15:0] CRC_POLY   = 16'h8005;
  localparam logic [15:0] CRC_INIT   = 16'h0000;

  localparam logic [7:0] RST_WRITE_CODE    = 8'd130;
  localparam logic [7:0] RST_VAR_READ_CODE = 8'd131;
  localparam logic [7:0] RST_REG_READ_CODE = 8'd129;

  // One unit of work for the serializer: a frame header or one payload byte.
  // For a payload job, val holds the data byte; for a header, the count.
  typedef struct packed {
    logic        is_hdr;
    logic [2:0]  kind;
    logic [15:0] addr;
    logic [7:0]  val;
    logic        ends;
  } dcf_job_t;

  typedef struct packed {
    logic       crc_enable;
    logic [7:0] write_code;
    logic [7:0] var_read_code;
    logic [7:0] reg_read_code;
  } dcf_cfg_t;

  // CRC-16, MSB first, no reflection, one byte.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // Number of header bytes for a frame kind.
  function automatic logic [3:0] hdr_nbytes(input logic [2:0] kind);
    logic [3:0] n;
    case (kind)
      KIND_VAR_WR:   n = 4'd6;
      KIND_VAR_RD:   n = 4'd7;
      KIND_CURVE_WR: n = 4'd5;
      KIND_REG_WR:   n = 4'd5;
      default:       n = 4'd6;
    endcase
    return n;
  endfunction

endpackage

/* hdl/dcf_in_if.sv */
// Input channel of the display command framer: frame begins and payload bytes.
// Standalone; carries valid/ready and the item fields.
interface dcf_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [2:0]  frame_kind;
  logic [15:0] address;
  logic [7:0]  count;
  logic [7:0]  data_byte;

  modport source(output valid, action, frame_kind, address, count, data_byte, input ready);
  modport sink(input valid, action, frame_kind, address, count, data_byte, output ready);
endinterface

/* hdl/dcf_out_if.sv */
// Output channel of the display command framer: one serial byte per transaction.
// Standalone; carries valid/ready, the byte and the end-of-frame mark.
interface dcf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;

  modport source(output valid, tx_byte, last_byte, input ready);
  modport sink(input valid, tx_byte, last_byte, output ready);
endinterface

/* hdl/display_command_framer_crc16_top.sv */
// Display command framer with optional CRC-16: top level.
// Depends on dcf_pkg, dcf_in_if, dcf_out_if, dcf_cfg_regs, dcf_front,
// dcf_queue and dcf_back.
//
// in_ch carries frame begins (action 0) and payload bytes (action 1).
// A begin of a known kind produces the 5 to 7 header bytes of the frame,
// plus two CRC bytes when the frame closes with CRC enabled; each payload
// byte produces one output byte, plus, with CRC enabled, the CRC pair on the final one.
// out_ch delivers one frame byte per transaction, last_byte on the final one.
// Stray payload bytes and unknown frame kinds produce nothing.
// With the serializer idle, an accepted item is first written to the job
// queue, then its first byte is registered into the out_ch output register.
// While the receiver is ready the serializer sends one byte per cycle, so
// payload streams at one item per cycle bar CRC pairs; a header holds it longer.
// A job queue of QueueDepth entries sits between the front end and the
// serializer; in_ch.ready drops only when that queue is full.
// If the receiver stalls, the output register holds its byte and the queue
// keeps absorbing items until it fills.
// Reset (synchronous, active low) empties the queue, clears the output and
// the pending payload count, and restores register defaults.
// Registers (cfg_ port, 4*i): crc_enable, write_code, var_read_code,
// reg_read_code; change them only while the block is idle.
module display_command_framer_crc16_top #(
  parameter int QueueDepth = dcf_pkg::DCF_QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  dcf_in_if.sink                     in_ch,
  dcf_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [dcf_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [dcf_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [dcf_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import dcf_pkg::*;

  dcf_cfg_t cfg;
  dcf_job_t push_job, head_job;
  logic     push, q_full, pop, head_valid;

  dcf_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  dcf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  dcf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  dcf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

/* hdl/dcf_cfg_regs.sv */
// APB-style configuration registers of the display command framer.
// Depends on dcf_pkg for register indexes, widths and reset values.
module dcf_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dcf_pkg::CFG_AW-1:0] paddr,
  input  logic [dcf_pkg::CFG_DW-1:0] pwdata,
  output logic [dcf_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output dcf_pkg::dcf_cfg_t          cfg
);
  import dcf_pkg::*;

  dcf_cfg_t   cfg_r, cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_CRC_ENABLE:    cfg_nxt.crc_enable    = pwdata[0];
        REG_WRITE_CODE:    cfg_nxt.write_code    = pwdata[7:0];
        REG_VAR_READ_CODE: cfg_nxt.var_read_code = pwdata[7:0];
        REG_REG_READ_CODE: cfg_nxt.reg_read_code = pwdata[7:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CRC_ENABLE:    prdata = {{(CFG_DW-1){1'b0}}, cfg_r.crc_enable};
      REG_WRITE_CODE:    prdata = {{(CFG_DW-8){1'b0}}, cfg_r.write_code};
      REG_VAR_READ_CODE: prdata = {{(CFG_DW-8){1'b0}}, cfg_r.var_read_code};
      REG_REG_READ_CODE: prdata = {{(CFG_DW-8){1'b0}}, cfg_r.reg_read_code};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.crc_enable    <= 1'b0;
      cfg_r.write_code    <= RST_WRITE_CODE;
      cfg_r.var_read_code <= RST_VAR_READ_CODE;
      cfg_r.reg_read_code <= RST_REG_READ_CODE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* hdl/dcf_front.sv */
// Front end: accepts input transactions, tracks pending payload and turns
// each useful item into a job for the queue. Depends on dcf_pkg, dcf_in_if.
module dcf_front (
  input  logic              clk,
  input  logic              rst_n,
  dcf_in_if.sink            in_ch,
  input  logic              q_full,
  output logic              push,
  output dcf_pkg::dcf_job_t push_job
);
  import dcf_pkg::*;

  logic [7:0] payload_left_r, payload_left_nxt;
  logic       accept;
  logic       is_write;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_write    = (in_ch.frame_kind == KIND_VAR_WR) ||
                       (in_ch.frame_kind == KIND_CURVE_WR) ||
                       (in_ch.frame_kind == KIND_REG_WR);

  always_comb begin
    push_job.is_hdr  = (in_ch.action == ACT_BEGIN);
    push_job.kind    = in_ch.frame_kind;
    push_job.addr    = in_ch.address;
    push_job.val     = (in_ch.action == ACT_BEGIN) ? in_ch.count : in_ch.data_byte;
    push_job.ends    = 1'b0;
    push             = 1'b0;
    payload_left_nxt = payload_left_r;
    if (accept) begin
      if (in_ch.action == ACT_DATA) begin
        // Payload with nothing pending is dropped.
        if (payload_left_r != 8'd0) begin
          push             = 1'b1;
          push_job.ends    = (payload_left_r == 8'd1);
          payload_left_nxt = payload_left_r - 8'd1;
        end
      end else if (in_ch.frame_kind <= KIND_REG_RD) begin
        push             = 1'b1;
        payload_left_nxt = is_write ? in_ch.count : 8'd0;
        push_job.ends    = !is_write || (in_ch.count == 8'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      payload_left_r <= 8'd0;
    end else begin
      payload_left_r <= payload_left_nxt;
    end
  end

endmodule

/* hdl/dcf_queue.sv */
// Small register FIFO of jobs between the front end and the serializer.
// Depends on dcf_pkg for the job type.
module dcf_queue #(
  parameter int Depth = dcf_pkg::DCF_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dcf_pkg::dcf_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output dcf_pkg::dcf_job_t head_job
);
  import dcf_pkg::*;

  localparam int IW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);
  localparam logic [IW-1:0] LastIdx = IW'(Depth - 1);

  dcf_job_t        mem_r [Depth];
  logic [IW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full       = (cnt_r == CW'(Depth));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastIdx) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastIdx) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* hdl/dcf_back.sv */
// Serializer: walks each queued job byte by byte, keeps the running CRC and
// drives the output register. Depends on dcf_pkg and dcf_out_if.
module dcf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  dcf_pkg::dcf_cfg_t cfg,
  input  logic              head_valid,
  input  dcf_pkg::dcf_job_t head_job,
  output logic              pop,
  dcf_out_if.source         out_ch
);
  import dcf_pkg::*;

  logic [3:0]  step_r, step_nxt;
  logic [15:0] crc_r, crc_nxt, crc_base;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  tx_r, tx_nxt;
  logic        last_r, last_nxt;
  logic        fire;
  logic [3:0]  nbody;
  logic        has_crc;
  logic        in_body;
  logic        covered;
  logic        done;
  logic [7:0]  body_byte;
  logic [7:0]  len_byte;
  logic [7:0]  code_byte;
  logic        var_frame;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.tx_byte   = tx_r;
  assign out_ch.last_byte = last_r;

  assign fire      = head_valid && (!out_valid_r || out_ch.ready);
  assign nbody     = head_job.is_hdr ? hdr_nbytes(head_job.kind) : 4'd1;
  assign has_crc   = head_job.ends && cfg.crc_enable;
  assign in_body   = (step_r < nbody);
  assign covered   = !head_job.is_hdr || (step_r >= 4'd3);
  assign var_frame = (head_job.kind == KIND_VAR_WR) || (head_job.kind == KIND_VAR_RD);
  assign done      = has_crc ? (step_r == nbody + 4'd1) : (step_r == nbody - 4'd1);
  assign pop       = fire && done;

  always_comb begin
    case (head_job.kind)
      KIND_VAR_WR: len_byte = head_job.val + 8'd3;
      KIND_VAR_RD: len_byte = LEN_VAR_RD;
      KIND_REG_RD: len_byte = LEN_REG_RD;
      default:     len_byte = head_job.val + 8'd2;
    endcase
    case (head_job.kind)
      KIND_VAR_RD: code_byte = cfg.var_read_code;
      KIND_REG_RD: code_byte = cfg.reg_read_code;
      default:     code_byte = cfg.write_code;
    endcase
  end

  // Header layout: sync pair, length, command, address, then the read count.
  always_comb begin
    if (!head_job.is_hdr) begin
      body_byte = head_job.val;
    end else begin
      case (step_r)
        4'd0:    body_byte = SYNC_HI;
        4'd1:    body_byte = SYNC_LO;
        4'd2:    body_byte = len_byte;
        4'd3:    body_byte = code_byte;
        4'd4:    body_byte = var_frame ? head_job.addr[15:8] : head_job.addr[7:0];
        4'd5:    body_byte = var_frame ? head_job.addr[7:0] : head_job.val;
        default: body_byte = head_job.val;
      endcase
    end
  end

  always_comb begin
    step_nxt      = step_r;
    crc_nxt       = crc_r;
    tx_nxt        = tx_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    crc_base      = (head_job.is_hdr && step_r == 4'd0) ? CRC_INIT : crc_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
      step_nxt      = done ? 4'd0 : step_r + 4'd1;
      if (in_body) begin
        tx_nxt   = body_byte;
        last_nxt = head_job.ends && !cfg.crc_enable && (step_r == nbody - 4'd1);
        crc_nxt  = covered ? crc16_byte(crc_base, body_byte) : crc_base;
      end else if (step_r == nbody) begin
        tx_nxt   = crc_r[7:0];
        last_nxt = 1'b0;
      end else begin
        tx_nxt   = crc_r[15:8];
        last_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    tx_r   <= tx_nxt;
    last_r <= last_nxt;
    crc_r  <= crc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hdl/dcf_checker.sv */
// Port-level checker for the display command framer, bound to the top level.
// Depends on display_command_framer_crc16_top_assert.svh for its macros.
`include "display_command_framer_crc16_top_assert.svh"

module dcf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] tx_byte,
  input logic       last_byte
);

  // A stalled output transaction keeps its byte and its end mark.
  `DCF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(last_byte), "output changed while stalled")

  // Reset leaves no byte on the output.
  `DCF_ASSERT_ALWAYS(a_rst_out_idle, !rst_n |=> !out_valid, "output valid right after reset")

  // Reset empties the job queue, so input is taken at once.
  `DCF_ASSERT_ALWAYS(a_rst_in_ready, !rst_n |=> in_ready, "input not ready right after reset")

endmodule

bind display_command_framer_crc16_top dcf_checker u_dcf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .tx_byte   (out_ch.tx_byte),
  .last_byte (out_ch.last_byte)
);
